// ===== design/fbfl_pkg.sv =====
// Shared types and constants for the fixed-block free-list allocator.
// No dependencies; the allocator and fbfl_init refer to this package by scope.
package fbfl_pkg;

  localparam int SIZE_W         = 13;
  localparam int SIZE_RESET     = 16;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int MAX_BLOCKS_DEF = 512;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT  = 3'b001,
    ST_IDLE  = 3'b010,
    ST_ALLOC = 3'b100
  } fbfl_state_t;

  // status of the link-chain init sweep
  typedef struct packed {
    logic busy;
    logic done;
  } fbfl_init_stat_t;

endpackage

// ===== design/fixed_block_free_list_allocator.sv =====
// Fixed-block allocator: LIFO free list of next links in one memory.
// Output: free and failed alloc give their word in the cycle after acceptance;
// a successful alloc first passes through ST_ALLOC for the link memory read.
// One free per cycle while the output is not stalled; a new alloc waits for the pop.
// Reset and each cfg write start an init sweep that chains all blocks;
// input is stalled during it. Uses fbfl_pkg, fbfl_init, fbfl_ram.
module fixed_block_free_list_allocator #(
  parameter int PAGE_BYTES = fbfl_pkg::PAGE_BYTES_DEF,
  parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fbfl_pkg::SIZE_W-1:0]     cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [$clog2(MAX_BLOCKS)-1:0]   in_free_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_ok,
  output logic [$clog2(MAX_BLOCKS)-1:0]   out_block_index,
  output logic [$clog2(PAGE_BYTES)-1:0]   out_byte_offset,
  output logic [$clog2(MAX_BLOCKS+1)-1:0] out_free_left
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int OW = $clog2(PAGE_BYTES);
  localparam int SW = fbfl_pkg::SIZE_W;
  localparam int PW = IW + SW;

  fbfl_pkg::fbfl_state_t state_r, state_nxt;
  logic [SW-1:0]   block_size_r, block_size_nxt;
  logic            start_r, start_nxt;
  logic [LW-1:0]   head_r, head_nxt;
  logic [LW-1:0]   free_total_r, free_total_nxt;
  logic [LW-1:0]   block_count_r, block_count_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_ok_r, out_ok_nxt;
  logic [IW-1:0]   out_block_index_r, out_block_index_nxt;
  logic [OW-1:0]   out_byte_offset_r, out_byte_offset_nxt;
  logic [LW-1:0]   out_free_left_r, out_free_left_nxt;

  logic            in_acc;
  logic            alloc_ok;
  logic            free_ok;
  logic [SW-1:0]   eff_size;
  logic [PW-1:0]   prod;

  fbfl_pkg::fbfl_init_stat_t init_stat;
  logic            init_we;
  logic [IW-1:0]   init_waddr;
  logic [LW-1:0]   init_wdata;
  logic [LW-1:0]   init_count;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [LW-1:0]   ram_wdata;
  logic            ram_re;
  logic [LW-1:0]   ram_rdata;

  assign eff_size = (block_size_r == '0) ? SW'(1) : block_size_r;
  assign in_stall = (state_r != fbfl_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign alloc_ok = (free_total_r != '0) && (head_r < LW'(MAX_BLOCKS));
  assign free_ok  = LW'(in_free_index) < block_count_r;
  assign prod     = PW'(head_r[IW-1:0]) * PW'(eff_size);

  fbfl_init #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_init (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .eff_size (eff_size),
    .wr_en    (init_we),
    .wr_addr  (init_waddr),
    .wr_data  (init_wdata),
    .count    (init_count),
    .stat     (init_stat)
  );

  // init sweep owns the write port; otherwise a free pushes onto the list
  always_comb begin
    if (init_stat.busy) begin
      ram_we    = init_we;
      ram_waddr = init_waddr;
      ram_wdata = init_wdata;
    end else begin
      ram_we    = in_acc && (in_func == fbfl_pkg::FUNC_FREE) && free_ok;
      ram_waddr = in_free_index;
      ram_wdata = head_r;
    end
  end

  assign ram_re = in_acc && (in_func == fbfl_pkg::FUNC_ALLOC) && alloc_ok;

  fbfl_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_BLOCKS)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt           = state_r;
    block_size_nxt      = block_size_r;
    start_nxt           = 1'b0;
    head_nxt            = head_r;
    free_total_nxt      = free_total_r;
    block_count_nxt     = block_count_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_ok_nxt          = out_ok_r;
    out_block_index_nxt = out_block_index_r;
    out_byte_offset_nxt = out_byte_offset_r;
    out_free_left_nxt   = out_free_left_r;

    unique case (state_r)
      fbfl_pkg::ST_INIT: begin
        if (init_stat.done && !start_r) begin
          block_count_nxt = init_count;
          free_total_nxt  = init_count;
          head_nxt        = (init_count != '0) ? '0 : LW'(MAX_BLOCKS);
          state_nxt       = fbfl_pkg::ST_IDLE;
        end
      end
      fbfl_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_func == fbfl_pkg::FUNC_FREE) begin
            if (free_ok) begin
              head_nxt = LW'(in_free_index);
              if (free_total_r < block_count_r) begin
                free_total_nxt = free_total_r + LW'(1);
              end
            end
            out_valid_nxt       = 1'b1;
            out_ok_nxt          = free_ok;
            out_block_index_nxt = '0;
            out_byte_offset_nxt = '0;
            out_free_left_nxt   = free_total_nxt;
          end else if (alloc_ok) begin
            // pop finishes once the head's link comes back from memory
            free_total_nxt = free_total_r - LW'(1);
            state_nxt      = fbfl_pkg::ST_ALLOC;
          end else begin
            out_valid_nxt       = 1'b1;
            out_ok_nxt          = 1'b0;
            out_block_index_nxt = '0;
            out_byte_offset_nxt = '0;
            out_free_left_nxt   = '0;
          end
        end
      end
      fbfl_pkg::ST_ALLOC: begin
        head_nxt            = ram_rdata;
        out_valid_nxt       = 1'b1;
        out_ok_nxt          = 1'b1;
        out_block_index_nxt = head_r[IW-1:0];
        out_byte_offset_nxt = prod[OW-1:0];
        out_free_left_nxt   = free_total_r;
        state_nxt           = fbfl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fbfl_pkg::ST_INIT;
        start_nxt = 1'b1;
      end
    endcase

    if (cfg_wr_en) begin
      block_size_nxt = cfg_wr_data;
      start_nxt      = 1'b1;
      state_nxt      = fbfl_pkg::ST_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= fbfl_pkg::ST_INIT;
      block_size_r  <= SW'(fbfl_pkg::SIZE_RESET);
      start_r       <= 1'b1;
      head_r        <= LW'(MAX_BLOCKS);
      free_total_r  <= '0;
      block_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      block_size_r  <= block_size_nxt;
      start_r       <= start_nxt;
      head_r        <= head_nxt;
      free_total_r  <= free_total_nxt;
      block_count_r <= block_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r          <= out_ok_nxt;
    out_block_index_r <= out_block_index_nxt;
    out_byte_offset_r <= out_byte_offset_nxt;
    out_free_left_r   <= out_free_left_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_block_index = out_block_index_r;
  assign out_byte_offset = out_byte_offset_r;
  assign out_free_left   = out_free_left_r;

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fbfl_pkg::ST_IDLE) |-> free_total_r <= block_count_r)
    else $error("free count above block count");

  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fbfl_pkg::ST_ALLOC) |-> !out_valid_r)
    else $error("pop completes with output word still pending");

  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_stat.busy |-> in_stall)
    else $error("word accepted during init sweep");

  a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fbfl_pkg::ST_ALLOC) && !cfg_wr_en |=> (state_r == fbfl_pkg::ST_IDLE) && out_valid_r)
    else $error("pop did not complete in one cycle");

endmodule

// ===== design/fbfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbfl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/fbfl_init.sv =====
// Init sweep: writes the ascending link chain into the free-list memory and
// counts blocks by accumulating the block size. Depends on fbfl_pkg.
module fbfl_init #(
  parameter int PAGE_BYTES = fbfl_pkg::PAGE_BYTES_DEF,
  parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [fbfl_pkg::SIZE_W-1:0]     eff_size,
  output logic                            wr_en,
  output logic [$clog2(MAX_BLOCKS)-1:0]   wr_addr,
  output logic [$clog2(MAX_BLOCKS+1)-1:0] wr_data,
  output logic [$clog2(MAX_BLOCKS+1)-1:0] count,
  output fbfl_pkg::fbfl_init_stat_t       stat
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  // holds (i+1)*size, which stops growing once it passes the page
  localparam int AW = $clog2(PAGE_BYTES + 2 * (2 ** fbfl_pkg::SIZE_W)) + 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] acc_sum;
  logic          fits_cur;
  logic          link_more;
  logic          last;

  assign acc_sum  = acc_r + AW'(eff_size);
  assign fits_cur = acc_r <= AW'(PAGE_BYTES);
  assign last     = idx_r == IW'(MAX_BLOCKS - 1);
  // link i points on only if block i+1 also fits
  assign link_more = (acc_sum <= AW'(PAGE_BYTES)) && !last;

  assign wr_en   = busy_r;
  assign wr_addr = idx_r;
  assign wr_data = link_more ? (LW'(idx_r) + LW'(1)) : LW'(MAX_BLOCKS);
  assign count   = cnt_r;
  assign stat    = '{busy: busy_r, done: done_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    idx_nxt  = idx_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      acc_nxt  = AW'(eff_size);
      cnt_nxt  = '0;
    end else if (busy_r) begin
      idx_nxt = idx_r + IW'(1);
      if (fits_cur) begin
        cnt_nxt = cnt_r + LW'(1);
        acc_nxt = acc_sum;
      end
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("init done without a finished sweep");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> cnt_r <= LW'(MAX_BLOCKS))
    else $error("block count above maximum");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> wr_data <= LW'(MAX_BLOCKS))
    else $error("init link out of range");

endmodule
